/* rtl/trn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package trn_pkg;

  // Token framing constants.
  localparam logic [7:0] CRC_SEED     = 8'h88;
  localparam logic [3:0] ERR_CRC_CODE = 4'hC;
  localparam int         STORE_BIT    = 3;
  localparam logic [3:0] BROADCAST_ID = 4'h0;

  // Per-bit contributions of the reflected CRC-8 (poly 0x31) byte step.
  localparam logic [7:0] CRC_TAB [8] = '{
    8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
  };

  // One classified token handed from the front end to the transmitter.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       cleared;
    logic       event_hit;
    logic [7:0] ctarget;
  } token_t;

  // Advance the CRC by one byte.
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = acc ^ b;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) r = r ^ CRC_TAB[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/trn_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module trn_front #(
  parameter int REG_COUNT = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          in_frame_restart,
  input  wire logic          cfg_valid,
  input  wire logic [3:0]    cfg_node_id,
  input  wire logic          q_full,
  output logic               q_push,
  output trn_pkg::token_t    q_token
);
  import trn_pkg::*;

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [3:0]  node_id_r;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  b0_r, b1_r, b2_r;
  logic [15:0] rf_r [REG_COUNT];

  logic        accept;
  logic [1:0]  eff_idx;
  logic [7:0]  crc_base;
  logic        is_last;
  logic        crc_good;
  logic [3:0]  tid;
  logic        own;
  logic        addressed;
  logic [2:0]  reg_sel;
  logic        in_range;
  logic [15:0] old_val;
  logic        do_write;

  // Accept whenever the token queue has room.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Node identity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 4'd1;
    end else if (cfg_valid) begin
      node_id_r <= cfg_node_id;
    end
  end

  // A restart forces the word to be the first of a new token.
  assign eff_idx  = in_frame_restart ? 2'd0 : idx_r;
  assign crc_base = in_frame_restart ? CRC_SEED : crc_r;
  assign is_last  = (eff_idx == 2'd3);

  always_comb begin
    if (is_last) begin
      idx_nxt = 2'd0;
      crc_nxt = CRC_SEED;
    end else begin
      idx_nxt = eff_idx + 2'd1;
      crc_nxt = crc_step(crc_base, in_rx_byte);
    end
  end

  // Gathering state and the running CRC over the first three words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      crc_r <= CRC_SEED;
    end else if (accept) begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (eff_idx)
        2'd0:    b0_r <= in_rx_byte;
        2'd1:    b1_r <= in_rx_byte;
        2'd2:    b2_r <= in_rx_byte;
        default: ;
      endcase
    end
  end

  // Classification of a complete token.
  assign crc_good  = (crc_r == in_rx_byte);
  assign tid       = b2_r[7:4];
  assign own       = (tid == node_id_r);
  assign addressed = own || (tid == BROADCAST_ID);
  assign reg_sel   = b2_r[2:0];
  assign in_range  = (32'(reg_sel) < REG_COUNT);
  assign old_val   = in_range ? rf_r[reg_sel[IDX_W-1:0]] : 16'h0000;
  assign do_write  = accept && is_last && crc_good && addressed && b2_r[STORE_BIT] && in_range;

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= 16'h0000;
      end
    end else if (do_write) begin
      rf_r[reg_sel[IDX_W-1:0]] <= {b1_r, b0_r};
    end
  end

  // Build the outgoing token.
  always_comb begin
    q_token = '0;
    if (crc_good) begin
      q_token.b0        = (addressed && own) ? old_val[7:0]  : b0_r;
      q_token.b1        = (addressed && own) ? old_val[15:8] : b1_r;
      q_token.b2        = b2_r;
      q_token.cleared   = own && (reg_sel == 3'd0);
      q_token.event_hit = addressed && (b2_r != 8'h00);
      q_token.ctarget   = (addressed && (b2_r != 8'h00)) ? b2_r : 8'h00;
    end else begin
      q_token.b0 = crc_r;
      q_token.b1 = in_rx_byte;
      q_token.b2 = {node_id_r, ERR_CRC_CODE ^ b2_r[3:0]};
    end
  end

  assign q_push = accept && is_last;

endmodule

`default_nettype wire

/* rtl/trn_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module trn_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire trn_pkg::token_t  push_token,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output trn_pkg::token_t       head
);
  import trn_pkg::*;

  token_t     slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Two-entry token queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

`default_nettype wire

/* rtl/trn_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module trn_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_not_empty,
  input  wire trn_pkg::token_t  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_tx_byte,
  output logic                  out_last_byte,
  output logic                  out_status_cleared,
  output logic                  out_control_event,
  output logic [7:0]            out_control_target
);
  import trn_pkg::*;

  logic [1:0] k_r;
  logic [7:0] crc_r, crc_nxt;
  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, cleared_r, event_r;
  logic [7:0] ctarget_r;
  logic       load;

  // Load a queued word when the output register is empty or being taken.
  assign load  = q_not_empty && (!valid_r || out_ready);
  assign q_pop = load && (k_r == 2'd3);

  // Pick the word to send and advance the fresh CRC.
  always_comb begin
    unique case (k_r)
      2'd0: begin
        byte_nxt = q_head.b0;
        crc_nxt  = crc_step(CRC_SEED, q_head.b0);
      end
      2'd1: begin
        byte_nxt = q_head.b1;
        crc_nxt  = crc_step(crc_r, q_head.b1);
      end
      2'd2: begin
        byte_nxt = q_head.b2;
        crc_nxt  = crc_step(crc_r, q_head.b2);
      end
      default: begin
        byte_nxt = crc_r;
        crc_nxt  = crc_r;
      end
    endcase
  end

  // Word position and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        k_r     <= k_r + 2'd1;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      crc_r     <= crc_nxt;
      byte_r    <= byte_nxt;
      last_r    <= (k_r == 2'd3);
      cleared_r <= (k_r == 2'd0) && q_head.cleared;
      event_r   <= (k_r == 2'd0) && q_head.event_hit;
      ctarget_r <= (k_r == 2'd0) ? q_head.ctarget : 8'h00;
    end
  end

  assign out_valid          = valid_r;
  assign out_tx_byte        = byte_r;
  assign out_last_byte      = last_r;
  assign out_status_cleared = cleared_r;
  assign out_control_event  = event_r;
  assign out_control_target = ctarget_r;

endmodule

`default_nettype wire

/* rtl/token_ring_register_node.sv */
// Ring node register port.
// Input channel (in_valid/in_ready) takes one received word per cycle while the
// queue has room: the byte and a flag that marks it as the first word of a
// token. Every fourth word completes a token; its CRC is checked, the register
// file is read and optionally written, and the token is queued for
// retransmission. Output channel (out_valid/out_ready) sends the four words of
// each token in the order data low, data high, target, CRC, one word per cycle
// while out_ready is high; the last one carries out_last_byte. Event flags
// appear on the first word only. The output is registered. Sustained rate is
// one word per cycle on each side while out_ready stays high, set by the
// transmitter which sends one word of the head token per cycle. A two-token
// queue sits between receiver and transmitter; when the receiver of our output
// stalls, the queue fills and in_ready drops only once it is full.
// Configuration (cfg_valid/cfg_ready, always ready) writes the node id.
// Reset clears the register file, sets the node id to 1, discards any partial
// token and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module token_ring_register_node #(
  parameter int REG_COUNT = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_restart,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_tx_byte,
  output logic            out_last_byte,
  output logic            out_status_cleared,
  output logic            out_control_event,
  output logic [7:0]      out_control_target,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_node_id
);
  import trn_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_not_empty;
  token_t q_token;
  token_t q_head;

  assign cfg_ready = 1'b1;

  // Receiver and token classifier.
  trn_front #(
    .REG_COUNT (REG_COUNT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_frame_restart (in_frame_restart),
    .cfg_valid        (cfg_valid),
    .cfg_node_id      (cfg_node_id),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_token          (q_token)
  );

  // Token queue.
  trn_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (q_token),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Transmitter.
  trn_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_byte        (out_tx_byte),
    .out_last_byte      (out_last_byte),
    .out_status_cleared (out_status_cleared),
    .out_control_event  (out_control_event),
    .out_control_target (out_control_target)
  );

endmodule

`default_nettype wire

/* rtl/trn_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module trn_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_tx_byte,
  input wire logic       out_last_byte,
  input wire logic       out_status_cleared,
  input wire logic       out_control_event,
  input wire logic [7:0] out_control_target
);

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte))
    else $error("output word changed while stalled");

  // An event always names a nonzero target.
  a_event_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_control_event |-> out_control_target != 8'h00)
    else $error("control event with zero target");

  // Without an event the target field is clear.
  a_no_event_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_control_event |-> out_control_target == 8'h00)
    else $error("control target without event");

  // Flags never ride on the CRC word.
  a_last_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> !out_status_cleared && !out_control_event)
    else $error("flags on last word of token");

endmodule

bind token_ring_register_node trn_checker u_trn_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_tx_byte        (out_tx_byte),
  .out_last_byte      (out_last_byte),
  .out_status_cleared (out_status_cleared),
  .out_control_event  (out_control_event),
  .out_control_target (out_control_target)
);

`default_nettype wire

/* sim/token_ring_register_node_tb.sv */
`timescale 1ns / 1ps

module token_ring_register_node_tb;
  import trn_pkg::*;

  localparam int NUM_REGS      = 8;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 30;
  // Reflected form of the CRC-8 polynomial 0x31, processed LSB first.
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_t;
  typedef enum {TGT_OWN, TGT_BCAST, TGT_OTHER} tgt_kind_t;

  // One outgoing word as the transmitter should present it.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
    logic       cleared;
    logic       ctrl_evt;
    logic [7:0] ctrl_target;
  } tx_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_frame_restart = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_last_byte;
  logic       out_status_cleared;
  logic       out_control_event;
  logic [7:0] out_control_target;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_node_id = 4'h0;

  // Mirror of the node: id, partial token and register file.
  logic [3:0]  node_id_cfg = 4'h1;
  logic [7:0]  rx_held [3] = '{8'h00, 8'h00, 8'h00};
  int          rx_count = 0;
  logic [15:0] node_regs [8] = '{default: 16'h0000};

  tx_word_t  tx_expect_q [$];
  int        errors = 0;
  int        words_sent = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b0;
  rdy_mode_t rdy_mode = RDY_ALWAYS;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        rdy_phase = 0;

  token_ring_register_node #(
    .REG_COUNT(NUM_REGS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_frame_restart  (in_frame_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_byte       (out_tx_byte),
    .out_last_byte     (out_last_byte),
    .out_status_cleared(out_status_cleared),
    .out_control_event (out_control_event),
    .out_control_target(out_control_target),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_node_id       (cfg_node_id)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that has not finished by now is stuck.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Bitwise CRC-8 over the three token bytes, seeded as the ring expects.
  function automatic logic [7:0] token_crc(input logic [7:0] d0, input logic [7:0] d1,
                                           input logic [7:0] d2);
    logic [7:0] acc;
    logic [7:0] bytes [3];
    bytes = '{d0, d1, d2};
    acc = CRC_SEED;
    foreach (bytes[i]) begin
      acc = acc ^ bytes[i];
      for (int j = 0; j < 8; j++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_POLY_REFL) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // Track one accepted word; a completed token yields four outgoing words.
  function automatic void ring_node_predict(input logic [7:0] rx, input logic restart);
    logic [7:0]  b0, b1, b2, calc, ctarget;
    logic [2:0]  ridx;
    logic [15:0] old_val;
    logic        cleared, hit;
    logic [7:0]  tok [4];
    tx_word_t    w;
    if (restart) rx_count = 0;
    if (rx_count < 3) begin
      rx_held[rx_count] = rx;
      rx_count++;
      return;
    end
    rx_count = 0;
    b0 = rx_held[0];
    b1 = rx_held[1];
    b2 = rx_held[2];
    calc = token_crc(b0, b1, b2);
    cleared = 1'b0;
    hit = 1'b0;
    ctarget = 8'h00;
    if (calc == rx) begin
      // Addressed to us, or broadcast: register access and control hook.
      if (b2[7:4] == node_id_cfg || b2[7:4] == BROADCAST_ID) begin
        ridx = b2[2:0];
        old_val = (ridx < NUM_REGS) ? node_regs[ridx] : 16'h0000;
        if (b2[STORE_BIT] && ridx < NUM_REGS) node_regs[ridx] = {b1, b0};
        if (b2[7:4] == node_id_cfg) begin
          b0 = old_val[7:0];
          b1 = old_val[15:8];
          cleared = (ridx == 3'd0);
        end
        if (b2 != 8'h00) begin
          hit = 1'b1;
          ctarget = b2;
        end
      end
    end else begin
      // Corrupted token: report both CRCs under our own id.
      b0 = calc;
      b1 = rx;
      b2 = {node_id_cfg, ERR_CRC_CODE ^ b2[3:0]};
    end
    tok = '{b0, b1, b2, token_crc(b0, b1, b2)};
    for (int k = 0; k < 4; k++) begin
      w.tx_byte     = tok[k];
      w.last        = (k == 3);
      w.cleared     = (k == 0) && cleared;
      w.ctrl_evt    = (k == 0) && hit;
      w.ctrl_target = (k == 0) ? ctarget : 8'h00;
      tx_expect_q.push_back(w);
    end
  endfunction

  // Receiver stalls as the mode selects, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rdy_mode)
        RDY_ALWAYS:  out_ready <= 1'b1;
        RDY_RANDOM:  out_ready <= ($urandom_range(99) >= 35);
        RDY_PATTERN: out_ready <= !(rdy_phase == 2 || rdy_phase == 5);
        default:     out_ready <= 1'b1;
      endcase
    end
    rdy_phase = (rdy_phase + 1) % 7;
  end

  // Compare each outgoing word with the oldest expectation.
  always @(posedge clk) begin
    tx_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (tx_expect_q.size() == 0) begin
        $error("unexpected outgoing word: tx_byte %02h", out_tx_byte);
        errors++;
      end else begin
        exp_w = tx_expect_q.pop_front();
        if (out_tx_byte !== exp_w.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", exp_w.tx_byte, out_tx_byte);
          errors++;
        end
        if (out_last_byte !== exp_w.last) begin
          $error("last_byte: expected %0b, got %0b", exp_w.last, out_last_byte);
          errors++;
        end
        if (out_status_cleared !== exp_w.cleared) begin
          $error("status_cleared: expected %0b, got %0b", exp_w.cleared,
                 out_status_cleared);
          errors++;
        end
        if (out_control_event !== exp_w.ctrl_evt) begin
          $error("control_event: expected %0b, got %0b", exp_w.ctrl_evt,
                 out_control_event);
          errors++;
        end
        if (out_control_target !== exp_w.ctrl_target) begin
          $error("control_target: expected %02h, got %02h", exp_w.ctrl_target,
                 out_control_target);
          errors++;
        end
      end
    end
  end

  // Offer one word and hold it until it is taken; gaps fall between bursts.
  task automatic send_word(input logic [7:0] b, input logic restart);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(12, 1);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_node_predict(b, restart);
    words_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // A whole token, with either its proper CRC or a corrupted one.
  task automatic send_token(input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] tgt,
                            input bit bad_crc, input logic restart);
    logic [7:0] crc;
    crc = token_crc(d0, d1, tgt);
    if (bad_crc) crc = crc ^ 8'($urandom_range(255, 1));
    send_word(d0, restart);
    send_word(d1, 1'b0);
    send_word(tgt, 1'b0);
    send_word(crc, 1'b0);
  endtask

  // Stop offering and let every outstanding token drain out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tx_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_id(input logic [3:0] id);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_node_id <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    node_id_cfg = id;
    cfg_valid <= 1'b0;
  endtask

  // Register access, broadcast, pass-through, bad CRC and restart, id 1.
  task automatic test_directed();
    gaps_on = 1'b0;
    rdy_mode = RDY_RANDOM;
    send_token(8'hFF, 8'hFF, 8'h1B, 1'b0, 1'b0);
    send_token(8'h00, 8'h00, 8'h13, 1'b0, 1'b1);
    send_token(8'hA5, 8'h00, 8'h08, 1'b0, 1'b1);
    send_token(8'h5A, 8'hC3, 8'h10, 1'b0, 1'b1);
    send_token(8'h77, 8'h88, 8'h00, 1'b0, 1'b1);
    send_token(8'h12, 8'h34, 8'hF5, 1'b0, 1'b1);
    send_token(8'h00, 8'hFF, 8'h1B, 1'b1, 1'b1);
    // A partial token is dropped when the next word restarts the frame.
    send_word(8'hDE, 1'b1);
    send_word(8'hAD, 1'b0);
    send_token(8'h01, 8'h80, 8'h1B, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Ids 15, 0 and 6, including id zero which answers to the broadcast nibble.
  task automatic test_node_ids();
    logic [3:0] ids [3];
    ids = '{4'hF, 4'h0, 4'h6};
    rdy_mode = RDY_PATTERN;
    gaps_on = 1'b1;
    foreach (ids[i]) begin
      write_node_id(ids[i]);
      send_token(8'h3C, 8'h96, {ids[i], 4'hB}, 1'b0, 1'b1);
      send_token(8'h00, 8'h00, {ids[i], 4'h3}, 1'b0, 1'b1);
      send_token(8'h69, 8'h0F, {ids[i], 4'h0}, 1'b1, 1'b1);
    end
    write_node_id(4'h1);
    wait_idle();
  endtask

  // Mostly well-formed tokens with random content, plus corruption and noise.
  task automatic test_random();
    int         goal, roll, noise_len;
    tgt_kind_t  kind;
    logic [3:0] nib;
    logic       rs;
    for (int phase = 0; phase < 3; phase++) begin
      write_node_id(4'($urandom_range(15, 1)));
      gaps_on = (phase != 0);
      rdy_mode = (phase == 0) ? RDY_ALWAYS : (phase == 1) ? RDY_RANDOM : RDY_PATTERN;
      goal = words_sent + RANDOM_WORDS / 3;
      while (words_sent < goal) begin
        roll = $urandom_range(99);
        if (roll < 88) begin
          kind = tgt_kind_t'($urandom_range(2));
          case (kind)
            TGT_OWN:   nib = node_id_cfg;
            TGT_BCAST: nib = BROADCAST_ID;
            default:   nib = 4'($urandom_range(15));
          endcase
          rs = (rx_count != 0) ? 1'b1 : 1'($urandom_range(1));
          send_token(8'($urandom), 8'($urandom), {nib, 4'($urandom)}, roll >= 75, rs);
        end else begin
          noise_len = $urandom_range(3, 1);
          repeat (noise_len) send_word(8'($urandom), 1'($urandom_range(1)));
        end
      end
    end
    wait_idle();
  endtask

  // Long receiver hold-off while the sender keeps offering tokens.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    rdy_mode = RDY_ALWAYS;
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_token(8'($urandom), 8'($urandom), {node_id_cfg, 4'($urandom)}, 1'b0, 1'b1);
    end
    wait_idle();
  endtask

  // Test sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_node_ids();
    test_random();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
